>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/stt_pkg.sv
package stt_pkg;

  localparam int POS_BITS  = 16;
  localparam int LINE_BITS = 16;
  localparam int LEN_BITS  = 16;
  localparam int MAX_TOKS  = 3;

  localparam logic [5:0] K_EOF     = 6'd0;
  localparam logic [5:0] K_BAD     = 6'd1;
  localparam logic [5:0] K_UNTERM  = 6'd2;
  localparam logic [5:0] K_IDENT   = 6'd3;
  localparam logic [5:0] K_NUMBER  = 6'd4;
  localparam logic [5:0] K_STRING  = 6'd5;
  localparam logic [5:0] K_LPAREN  = 6'd6;
  localparam logic [5:0] K_RPAREN  = 6'd7;
  localparam logic [5:0] K_LBRACE  = 6'd8;
  localparam logic [5:0] K_RBRACE  = 6'd9;
  localparam logic [5:0] K_COMMA   = 6'd10;
  localparam logic [5:0] K_PLUS    = 6'd11;
  localparam logic [5:0] K_MINUS   = 6'd12;
  localparam logic [5:0] K_STAR    = 6'd13;
  localparam logic [5:0] K_SLASH   = 6'd14;
  localparam logic [5:0] K_BANG    = 6'd15;
  localparam logic [5:0] K_OP_EQ   = 6'd16;
  localparam logic [5:0] K_KEYWORD = 6'd23;

  localparam logic [3:0] KW_NONE   = 4'd15;
  localparam logic [3:0] KW_RETURN = 4'd8;
  localparam logic [3:0] KW_REAL   = 4'd9;
  localparam logic [3:0] KW_COUNT  = 4'd10;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] line;
  } token_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    token_t [MAX_TOKS-1:0]      toks;
  } bundle_t;

  function automatic logic [2:0] kw_len(input logic [3:0] cand);
    logic [2:0] r;
    case (cand)
      4'd0: r = 3'd4;
      4'd1: r = 3'd2;
      4'd2: r = 3'd3;
      4'd3: r = 3'd5;
      4'd4: r = 3'd3;
      4'd5: r = 3'd3;
      4'd6: r = 3'd4;
      4'd7: r = 3'd2;
      4'd8: r = 3'd6;
      4'd9: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input logic [3:0] cand, input logic [2:0] i);
    logic [47:0] t;
    logic [7:0]  r;
    case (cand)
      4'd0: t = {"agar", 16'h0};
      4'd1: t = {"ya", 32'h0};
      4'd2: t = {"for", 24'h0};
      4'd3: t = {"while", 8'h0};
      4'd4: t = {"dac", 24'h0};
      4'd5: t = {"cap", 24'h0};
      4'd6: t = {"Plag", 16'h0};
      4'd7: t = {"Fn", 32'h0};
      4'd8: t = "return";
      4'd9: t = {"real", 16'h0};
      default: t = 48'h0;
    endcase
    case (i)
      3'd0: r = t[47:40];
      3'd1: r = t[39:32];
      3'd2: r = t[31:24];
      3'd3: r = t[23:16];
      3'd4: r = t[15:8];
      3'd5: r = t[7:0];
      default: r = 8'h0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] first_cand(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      "a": r = 4'd0;
      "y": r = 4'd1;
      "f": r = 4'd2;
      "w": r = 4'd3;
      "d": r = 4'd4;
      "c": r = 4'd5;
      "P": r = 4'd6;
      "F": r = 4'd7;
      "r": r = 4'd8;
      default: r = KW_NONE;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/stt_scan.sv
module stt_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_char,
  input  logic             q_full,
  output logic             push,
  output stt_pkg::bundle_t push_data
);
  import stt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SLASH   = 9'b000000010,
    S_COMMENT = 9'b000000100,
    S_IDENT   = 9'b000001000,
    S_NUMBER  = 9'b000010000,
    S_NUMDOT  = 9'b000100000,
    S_FRAC    = 9'b001000000,
    S_STRING  = 9'b010000000,
    S_OP      = 9'b100000000
  } mode_t;

  localparam logic [POS_BITS-1:0]  POS_ONE  = POS_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LEN_BITS-1:0]  LEN_ONE  = LEN_BITS'(1);

  mode_t                mode, mode_next;
  logic [1:0]           pend, pend_next;
  logic [POS_BITS-1:0]  pos, pos_next;
  logic [POS_BITS-1:0]  tstart, tstart_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic [3:0]           cand, cand_next;
  logic                 kok, kok_next;
  logic [LEN_BITS-1:0]  llen, llen_next;
  bundle_t              bnd;
  logic                 accept;

  function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
    return (v == '1) ? v : v + LEN_ONE;
  endfunction

  function automatic token_t mk(input logic [5:0] k, input logic [POS_BITS-1:0] o,
                                input logic [LEN_BITS-1:0] l,
                                input logic [LINE_BITS-1:0] ln);
    token_t t;
    t.kind   = k;
    t.offset = 16'(o);
    t.length = 16'(l);
    t.line   = 16'(ln);
    return t;
  endfunction

  assign accept    = in_valid && !q_full;
  assign in_ready  = !q_full;
  assign push      = accept && (bnd.cnt != 2'd0);
  assign push_data = bnd;

  always_comb begin
    logic [7:0] c;
    logic       reproc;
    logic       at_end;
    logic       alpha;
    logic       digit;
    logic [1:0] n;
    logic [3:0] kc;
    c           = in_char;
    reproc      = 1'b0;
    at_end      = 1'b0;
    n           = 2'd0;
    kc          = cand;
    alpha       = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    digit       = (c >= "0" && c <= "9");
    bnd         = '0;
    mode_next   = mode;
    pend_next   = pend;
    pos_next    = pos;
    tstart_next = tstart;
    line_next   = line;
    cand_next   = cand;
    kok_next    = kok;
    llen_next   = llen;

    unique case (mode)
      S_SLASH: begin
        if (c == "/") mode_next = S_COMMENT;
        else begin
          bnd.toks[n] = mk(K_SLASH, tstart, LEN_ONE, line);
          n = n + 2'd1;
          reproc = 1'b1;
        end
      end
      S_COMMENT: begin
        if (c == 8'h0A || c == 8'h00) reproc = 1'b1;
      end
      S_IDENT: begin
        if (alpha || digit || c == "_") begin
          if (kok && cand < KW_COUNT) begin
            if (cand == KW_RETURN && llen == LEN_BITS'(2) && c == "a") kc = KW_REAL;
            cand_next = kc;
            if (llen >= LEN_BITS'(kw_len(kc)) || kw_char(kc, llen[2:0]) != c)
              kok_next = 1'b0;
          end
          llen_next = sat_inc(llen);
        end else begin
          if (kok && cand < KW_COUNT && llen == LEN_BITS'(kw_len(cand)))
            bnd.toks[n] = mk(K_KEYWORD + 6'(cand), tstart, llen, line);
          else
            bnd.toks[n] = mk(K_IDENT, tstart, llen, line);
          n = n + 2'd1;
          reproc = 1'b1;
        end
      end
      S_NUMBER, S_FRAC: begin
        if (digit) llen_next = sat_inc(llen);
        else if (c == "." && mode == S_NUMBER) mode_next = S_NUMDOT;
        else begin
          bnd.toks[n] = mk(K_NUMBER, tstart, llen, line);
          n = n + 2'd1;
          reproc = 1'b1;
        end
      end
      S_NUMDOT: begin
        if (digit) begin
          llen_next = sat_inc(sat_inc(llen));
          mode_next = S_FRAC;
        end else begin
          bnd.toks[n] = mk(K_NUMBER, tstart, llen, line);
          n = n + 2'd1;
          bnd.toks[n] = mk(K_BAD, tstart + POS_BITS'(llen), LEN_ONE, line);
          n = n + 2'd1;
          reproc = 1'b1;
        end
      end
      S_STRING: begin
        if (c == "\"") begin
          bnd.toks[n] = mk(K_STRING, tstart, sat_inc(llen), line);
          n = n + 2'd1;
          llen_next = sat_inc(llen);
          mode_next = S_IDLE;
        end else if (c == 8'h00) begin
          bnd.toks[n] = mk(K_UNTERM, tstart, llen, line);
          n = n + 2'd1;
          reproc = 1'b1;
        end else begin
          if (c == 8'h0A && line != '1) line_next = line + LINE_ONE;
          llen_next = sat_inc(llen);
        end
      end
      S_OP: begin
        if (c == "=") begin
          bnd.toks[n] = mk(K_OP_EQ + {3'd0, pend, 1'b0}, tstart, LEN_BITS'(2), line);
          n = n + 2'd1;
          mode_next = S_IDLE;
        end else begin
          bnd.toks[n] = mk(K_BANG + {3'd0, pend, 1'b0}, tstart, LEN_ONE, line);
          n = n + 2'd1;
          reproc = 1'b1;
        end
      end
      default: reproc = 1'b1;
    endcase

    if (reproc) begin
      mode_next = S_IDLE;
      case (c)
        8'h00: begin
          bnd.toks[n] = mk(K_EOF, pos, '0, line);
          n = n + 2'd1;
          at_end = 1'b1;
        end
        " ", 8'h0D, 8'h09: ;
        8'h0A: if (line != '1) line_next = line + LINE_ONE;
        "/", "\"", "!", "=", "<", ">": begin
          tstart_next = pos;
          llen_next   = LEN_ONE;
          case (c)
            "/":  mode_next = S_SLASH;
            "\"": mode_next = S_STRING;
            default: mode_next = S_OP;
          endcase
          case (c)
            "!": pend_next = 2'd0;
            "=": pend_next = 2'd1;
            "<": pend_next = 2'd2;
            ">": pend_next = 2'd3;
            default: ;
          endcase
        end
        "(", ")", "{", "}", ",", "+", "-", "*": begin
          case (c)
            "(":     bnd.toks[n] = mk(K_LPAREN, pos, LEN_ONE, line);
            ")":     bnd.toks[n] = mk(K_RPAREN, pos, LEN_ONE, line);
            "{":     bnd.toks[n] = mk(K_LBRACE, pos, LEN_ONE, line);
            "}":     bnd.toks[n] = mk(K_RBRACE, pos, LEN_ONE, line);
            ",":     bnd.toks[n] = mk(K_COMMA, pos, LEN_ONE, line);
            "+":     bnd.toks[n] = mk(K_PLUS, pos, LEN_ONE, line);
            "-":     bnd.toks[n] = mk(K_MINUS, pos, LEN_ONE, line);
            default: bnd.toks[n] = mk(K_STAR, pos, LEN_ONE, line);
          endcase
          n = n + 2'd1;
        end
        default: begin
          if (alpha || c == "_") begin
            mode_next   = S_IDENT;
            tstart_next = pos;
            llen_next   = LEN_ONE;
            cand_next   = first_cand(c);
            kok_next    = (first_cand(c) != KW_NONE);
          end else if (digit) begin
            mode_next   = S_NUMBER;
            tstart_next = pos;
            llen_next   = LEN_ONE;
          end else begin
            bnd.toks[n] = mk(K_BAD, pos, LEN_ONE, line);
            n = n + 2'd1;
          end
        end
      endcase
    end

    bnd.cnt = n;

    if (at_end) begin
      mode_next   = S_IDLE;
      pend_next   = 2'd0;
      pos_next    = '0;
      tstart_next = '0;
      line_next   = LINE_ONE;
      cand_next   = KW_NONE;
      kok_next    = 1'b0;
      llen_next   = '0;
    end else begin
      pos_next = pos + POS_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= S_IDLE;
      pend   <= 2'd0;
      pos    <= '0;
      tstart <= '0;
      line   <= LINE_ONE;
      cand   <= KW_NONE;
      kok    <= 1'b0;
      llen   <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      pend   <= pend_next;
      pos    <= pos_next;
      tstart <= tstart_next;
      line   <= line_next;
      cand   <= cand_next;
      kok    <= kok_next;
      llen   <= llen_next;
    end
  end

endmodule

>>> rtl/stt_queue.sv
module stt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  stt_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output stt_pkg::bundle_t head
);
  import stt_pkg::*;

  bundle_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/stt_emit.sv
module stt_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  stt_pkg::bundle_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output stt_pkg::token_t  out_tok,
  output logic             out_last
);
  import stt_pkg::*;

  logic [1:0] sel;
  logic       load;
  logic       is_last;

  assign load    = !q_empty && (!out_valid || out_ready);
  assign is_last = (sel == q_head.cnt - 2'd1);
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= q_head.toks[sel];
      out_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 2'd0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      // advance within the bundle, wrap on its last token
      if (load) sel <= is_last ? 2'd0 : sel + 2'd1;
    end
  end

endmodule

>>> rtl/source_text_tokenizer_core.sv
// Channel  Dir  Beat content
// s_*      in   tdata[7:0] char_code
// m_*      out  tdata[5:0] token_kind, [21:6] token_offset, [37:22] token_length,
//               [53:38] line_number, [55:54] zero; tlast last_of_run
//
// One byte is scanned per cycle while the queue is not full; tokens leave one per
// cycle from a registered output while m_tready is high. A byte yielding several
// tokens holds the output until all have left; the two-bundle queue between
// scanner and emitter absorbs this, so input stalls only when it fills.
// Synchronous reset returns scanner state to idle, line 1, offset 0, and empties the queue.
module source_text_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // kind, offset, length, line, zero pad
  output logic        m_tlast
);
  import stt_pkg::*;
  `include "assert_macros.svh"

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  bundle_t q_in;
  bundle_t q_head;
  token_t  tok;

  stt_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_char   (s_tdata),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  stt_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tok   (tok),
    .out_last  (m_tlast)
  );

  assign m_tdata = {2'b00, tok.line, tok.length, tok.offset, tok.kind};

  `ASSERT_NEVER(a_no_overflow, clk, rst, q_push && q_full)
  `ASSERT_NEVER(a_no_empty_pop, clk, rst, q_pop && q_empty)
  `ASSERT_IMPLY(a_eof_last, clk, rst, m_tvalid && tok.kind == K_EOF, m_tlast)
  `ASSERT_IMPLY(a_line_nonzero, clk, rst, m_tvalid, tok.line != 16'd0)

endmodule

>>> tb/source_text_tokenizer_checker.sv
`timescale 1ns / 1ps

module source_text_tokenizer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending_tokens
);
  import stt_pkg::*;

  typedef enum logic [3:0] {
    SC_IDLE, SC_SLASH, SC_COMMENT, SC_IDENT, SC_NUMBER, SC_NUMDOT, SC_FRAC,
    SC_STRING, SC_OP
  } scan_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] line;
    logic        last;
  } tok_beat_t;

  tok_beat_t expected_tokens[$];

  scan_t       mode;
  logic [1:0]  op_sel;
  logic [15:0] pos_q;
  logic [15:0] start_q;
  logic [15:0] line_q;
  logic [3:0]  cand_q;
  logic        prefix_ok;
  logic [15:0] len_q;

  assign pending_tokens = expected_tokens.size();

  function automatic logic [7:0] kw_text_char(input logic [3:0] cand, input int i);
    string s;
    case (cand)
      4'd0: s = "agar";  4'd1: s = "ya";   4'd2: s = "for";  4'd3: s = "while";
      4'd4: s = "dac";   4'd5: s = "cap";  4'd6: s = "Plag"; 4'd7: s = "Fn";
      4'd8: s = "return"; 4'd9: s = "real"; default: s = "";
    endcase
    return (i < s.len()) ? s[i] : 8'h0;
  endfunction

  function automatic int kw_text_len(input logic [3:0] cand);
    int lens[10] = '{4, 2, 3, 5, 3, 3, 4, 2, 6, 4};
    return (cand < KW_COUNT) ? lens[cand] : 0;
  endfunction

  function automatic logic [3:0] kw_start(input logic [7:0] c);
    case (c)
      "a": return 4'd0; "y": return 4'd1; "f": return 4'd2; "w": return 4'd3;
      "d": return 4'd4; "c": return 4'd5; "P": return 4'd6; "F": return 4'd7;
      "r": return KW_RETURN;
      default: return KW_NONE;
    endcase
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void push_token(input logic [5:0] kind, input logic [15:0] off,
                                     input logic [15:0] len);
    tok_beat_t t;
    t.kind = kind; t.offset = off; t.length = len; t.line = line_q; t.last = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  task automatic len_bump();
    if (len_q != 16'hFFFF) len_q++;
  endtask

  function automatic void begin_token(input scan_t m, input logic [15:0] p);
    mode = m; start_q = p; len_q = 16'd1;
  endfunction

  task automatic clear_scan();
    mode = SC_IDLE; op_sel = '0; pos_q = '0; start_q = '0; line_q = 16'd1;
    cand_q = KW_NONE; prefix_ok = 1'b0; len_q = '0;
  endtask

  // Returns 1 on end of source.
  function automatic bit scan_idle(input logic [7:0] c, input logic [15:0] p);
    mode = SC_IDLE;
    case (c)
      8'd0: begin
        push_token(K_EOF, p, 16'd0);
        return 1'b1;
      end
      " ", 8'h0D, "\t": return 1'b0;
      "\n": begin
        if (line_q != 16'hFFFF) line_q++;
        return 1'b0;
      end
      "/": begin begin_token(SC_SLASH, p); return 1'b0; end
      "\"": begin begin_token(SC_STRING, p); return 1'b0; end
      "!": begin begin_token(SC_OP, p); op_sel = 2'd0; return 1'b0; end
      "=": begin begin_token(SC_OP, p); op_sel = 2'd1; return 1'b0; end
      "<": begin begin_token(SC_OP, p); op_sel = 2'd2; return 1'b0; end
      ">": begin begin_token(SC_OP, p); op_sel = 2'd3; return 1'b0; end
      "(": begin push_token(K_LPAREN, p, 16'd1); return 1'b0; end
      ")": begin push_token(K_RPAREN, p, 16'd1); return 1'b0; end
      "{": begin push_token(K_LBRACE, p, 16'd1); return 1'b0; end
      "}": begin push_token(K_RBRACE, p, 16'd1); return 1'b0; end
      ",": begin push_token(K_COMMA, p, 16'd1); return 1'b0; end
      "+": begin push_token(K_PLUS, p, 16'd1); return 1'b0; end
      "-": begin push_token(K_MINUS, p, 16'd1); return 1'b0; end
      "*": begin push_token(K_STAR, p, 16'd1); return 1'b0; end
      default: ;
    endcase
    if (is_letter(c) || c == "_") begin
      begin_token(SC_IDENT, p);
      cand_q = kw_start(c);
      prefix_ok = cand_q != KW_NONE;
    end else if (is_num(c)) begin
      begin_token(SC_NUMBER, p);
    end else begin
      push_token(K_BAD, p, 16'd1);
    end
    return 1'b0;
  endfunction

  task automatic scan_byte(input logic [7:0] c);
    logic [15:0] p;
    bit again;
    bit done;
    logic [5:0] k;
    int first;
    p = pos_q;
    again = 1'b0;
    done = 1'b0;
    first = expected_tokens.size();
    case (mode)
      SC_SLASH:
        if (c == "/") mode = SC_COMMENT;
        else begin push_token(K_SLASH, start_q, 16'd1); again = 1'b1; end
      SC_COMMENT: if (c == "\n" || c == 8'd0) again = 1'b1;
      SC_IDENT:
        if (is_letter(c) || is_num(c) || c == "_") begin
          if (prefix_ok && cand_q < KW_COUNT) begin
            if (cand_q == KW_RETURN && len_q == 16'd2 && c == "a") cand_q = KW_REAL;
            if (len_q >= kw_text_len(cand_q) || kw_text_char(cand_q, len_q) != c)
              prefix_ok = 1'b0;
          end
          len_bump();
        end else begin
          k = K_IDENT;
          if (prefix_ok && cand_q < KW_COUNT && len_q == kw_text_len(cand_q))
            k = K_KEYWORD + 6'(cand_q);
          push_token(k, start_q, len_q);
          again = 1'b1;
        end
      SC_NUMBER, SC_FRAC:
        if (is_num(c)) len_bump();
        else if (c == "." && mode == SC_NUMBER) mode = SC_NUMDOT;
        else begin push_token(K_NUMBER, start_q, len_q); again = 1'b1; end
      SC_NUMDOT:
        if (is_num(c)) begin
          len_bump(); len_bump(); mode = SC_FRAC;
        end else begin
          push_token(K_NUMBER, start_q, len_q);
          push_token(K_BAD, start_q + len_q, 16'd1);
          again = 1'b1;
        end
      SC_STRING:
        if (c == "\"") begin
          len_bump();
          push_token(K_STRING, start_q, len_q);
          mode = SC_IDLE;
        end else if (c == 8'd0) begin
          push_token(K_UNTERM, start_q, len_q);
          again = 1'b1;
        end else begin
          if (c == "\n" && line_q != 16'hFFFF) line_q++;
          len_bump();
        end
      SC_OP:
        if (c == "=") begin
          push_token(K_OP_EQ + 6'(2 * op_sel), start_q, 16'd2);
          mode = SC_IDLE;
        end else begin
          push_token(K_BANG + 6'(2 * op_sel), start_q, 16'd1);
          again = 1'b1;
        end
      default: again = 1'b1;
    endcase
    if (again) done = scan_idle(c, p);
    if (expected_tokens.size() > first)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    if (done) clear_scan();
    else pos_q = pos_q + 16'd1;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t token mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    tok_beat_t w;
    if (rst) begin
      clear_scan();
      expected_tokens.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected beat kind", 16'(m_tdata[5:0]), 16'hFFFF);
        end else begin
          w = expected_tokens.pop_front();
          if (m_tdata[5:0] != w.kind) report_mismatch("kind", 16'(m_tdata[5:0]), 16'(w.kind));
          if (m_tdata[21:6] != w.offset) report_mismatch("offset", m_tdata[21:6], w.offset);
          if (m_tdata[37:22] != w.length) report_mismatch("length", m_tdata[37:22], w.length);
          if (m_tdata[53:38] != w.line) report_mismatch("line", m_tdata[53:38], w.line);
          if (m_tdata[55:54] != 2'b00) report_mismatch("pad", 16'(m_tdata[55:54]), 16'd0);
          if (m_tlast != w.last) report_mismatch("tlast", 16'(m_tlast), 16'(w.last));
        end
      end
      if (s_tvalid && s_tready) scan_byte(s_tdata);
    end
  end

endmodule

>>> tb/source_text_tokenizer_core_tb.sv
`timescale 1ns / 1ps

module source_text_tokenizer_core_tb;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          pending_tokens;
  int          cycle_count;
  bit          quiet_phase;
  bit          hold_sink;
  int          sent;

  source_text_tokenizer_core u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  source_text_tokenizer_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .fail_count, .pending_tokens
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Sink: random stalls, none during the quiet phase, one long hold-off.
  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_sink) m_tready <= 1'b0;
      else m_tready <= quiet_phase || ($urandom_range(99) >= 6);
    end
  end

  initial begin
    hold_sink = 1'b0;
    wait (sent > 60);
    @(posedge clk);
    hold_sink <= 1'b1;
    repeat (40) @(posedge clk);
    hold_sink <= 1'b0;
  end

  // Offer one byte; hold tvalid across back-to-back beats.
  task automatic send_byte(input logic [7:0] c);
    if (!quiet_phase)
      while ($urandom_range(99) < 6) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string pick_lexeme();
    string words[14] = '{"agar", "ya", "for", "while", "dac", "cap", "Plag", "Fn",
                         "return", "real", "rea", "whiles", "x_1", "Fnx"};
    string ops[18] = '{"(", ")", "{", "}", ",", "+", "-", "*", "/", "!", "!=", "=",
                       "==", "<", "<=", ">", ">=", "."};
    string seps[5] = '{" ", "\n", "\t", "\015", ""};
    string s;
    case ($urandom_range(6))
      0, 1: s = words[$urandom_range(13)];
      2: s = $sformatf("%0d", $urandom_range(9999));
      3: s = $sformatf("%0d.%0d", $urandom_range(99), $urandom_range(99));
      4: s = ops[$urandom_range(17)];
      5: begin
        if ($urandom_range(1)) s = "\"ab\ncd\"";
        else s = "// note\n";
      end
      default: begin
        s = " ";
        s[0] = 8'($urandom_range(1, 255));
      end
    endcase
    return {s, seps[$urandom_range(4)]};
  endfunction

  initial begin
    string chunk;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    quiet_phase = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: keywords, operators, number edge cases, an unterminated string running to end of source.
    send_text("agar ya(x1)!=3.5<=>=,\n1.a+-*{}\xff");
    send_byte(8'd0);
    send_text("\"open\n//c\n/");
    send_byte(8'd0);
    send_byte(8'd0);

    while (sent < 430) begin
      if ($urandom_range(19) == 0) begin
        send_byte(8'd0);
      end else begin
        chunk = pick_lexeme();
        send_text(chunk);
      end
      if (sent > 250 && sent < 330) quiet_phase = 1'b1;
      else quiet_phase = 1'b0;
      // Pause the source until all tokens have drained.
      if (sent > 200 && sent < 215) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_tokens != 0) @(posedge clk);
      end
    end
    send_byte(8'd0);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tokens != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_tokens == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
